[src/vsms_pkg.sv]
// Shared types and codes for the voxel section mode store.
package vsms_pkg;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_FILL      = 3'd2;
  localparam logic [2:0] OP_RECOMPUTE = 3'd3;
  localparam logic [2:0] OP_ALLOCATE  = 3'd4;

  typedef enum logic [1:0] {
    MODE_EMPTY   = 2'd0,
    MODE_UNIFORM = 2'd1,
    MODE_MIXED   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR_ROW,
    ST_ADDR_COL,
    ST_REDUCE,
    ST_DISPATCH,
    ST_READ,
    ST_FILL,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_z;
    logic [7:0] palette_value;
  } vsms_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] storage_mode;
  } vsms_out_t;

endpackage

[src/voxel_section_mode_store.sv]
// Voxel section mode store: empty / uniform / mixed cell storage with a fill and scan sequencer.
//
//   channel | direction | payload     | handshake
//   in      | to block  | vsms_in_t   | in_valid, in_stall
//   out     | from block| vsms_out_t  | out_valid, out_stall
//
// Per item: accept, row and column multiply-add steps, a compare plus one subtract per
// multiple of CELLS in the raw address, dispatch, output load.
// A mixed read adds a read step, an upgrade adds a fill pass over all CELLS cells (plus a
// write step for a write), a recompute in mixed mode scans all cells; the single memory port forces this.
// Reset clears mode, uniform value and handshakes; the cell memory keeps no reset.
// A waiting result sits in the output register; the next item waits in its output cycle.
module voxel_section_mode_store #(
  parameter int EDGE  = 16,
  parameter int CELLS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsms_pkg::vsms_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vsms_pkg::vsms_out_t out_data
);
  import vsms_pkg::*;

  localparam int AW      = $clog2(CELLS);
  localparam int CNT_W   = AW + 1;
  localparam int RAW_MAX = (15 * EDGE + 15) * EDGE + 15;
  localparam int RAW_W   = $clog2(RAW_MAX + 1);
  localparam int CW      = (RAW_W > CNT_W) ? RAW_W : CNT_W;

  state_t state, state_next;
  mode_t  mode;
  logic [7:0] uniform_value;

  logic [2:0] op_r;
  logic [3:0] x_r, y_r, z_r;
  logic [7:0] value_r;

  logic [CW-1:0]    addr_acc;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       result_val;
  logic [7:0]       first;
  logic             first_seen;
  logic             all_zero;
  logic             cells_match;
  logic             rd_pend;

  logic [7:0]    mem [CELLS];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic       in_accept;
  logic       out_free;
  logic       addr_big;
  logic       fill_last;
  logic       scan_issue;
  logic       scan_end;
  logic [7:0] implied;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && (state == ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign addr_big   = (addr_acc >= CW'(CELLS));
  assign fill_last  = (cnt == CNT_W'(CELLS - 1));
  assign scan_issue = (cnt < CNT_W'(CELLS));
  assign scan_end   = !scan_issue && !rd_pend;
  assign implied    = (mode == MODE_UNIFORM) ? uniform_value : 8'd0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_ADDR_ROW;
      ST_ADDR_ROW: state_next = ST_ADDR_COL;
      ST_ADDR_COL: state_next = ST_REDUCE;
      ST_REDUCE:   if (!addr_big) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        state_next = ST_DONE;
        unique case (op_r)
          OP_READ: if (mode == MODE_MIXED) state_next = ST_READ;
          OP_WRITE: begin
            if (mode != MODE_MIXED && value_r != implied) state_next = ST_FILL;
          end
          OP_RECOMPUTE: if (mode == MODE_MIXED) state_next = ST_SCAN;
          OP_ALLOCATE:  if (mode != MODE_MIXED) state_next = ST_FILL;
          default:      state_next = ST_DONE;
        endcase
      end
      ST_READ:  state_next = ST_DONE;
      ST_FILL: begin
        if (fill_last) state_next = (op_r == OP_WRITE) ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_SCAN:  if (scan_end) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_acc[AW-1:0];
    mem_wdata = value_r;
    unique case (state)
      ST_DISPATCH: mem_we = (op_r == OP_WRITE) && (mode == MODE_MIXED);
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = cnt[AW-1:0];
        mem_wdata = implied;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_SCAN:  mem_addr = cnt[AW-1:0];
      default:  mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_EMPTY;
      uniform_value <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DISPATCH && op_r == OP_FILL) begin
        mode          <= (value_r == 8'd0) ? MODE_EMPTY : MODE_UNIFORM;
        uniform_value <= value_r;
      end
      if (state == ST_FILL && fill_last) mode <= MODE_MIXED;
      if (state == ST_SCAN && scan_end) begin
        if (all_zero) begin
          mode          <= MODE_EMPTY;
          uniform_value <= 8'd0;
        end else if (cells_match) begin
          mode          <= MODE_UNIFORM;
          uniform_value <= first;
        end
      end
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall)              out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_data.operation;
      x_r     <= in_data.cell_x;
      y_r     <= in_data.cell_y;
      z_r     <= in_data.cell_z;
      value_r <= in_data.palette_value;
    end
    unique case (state)
      ST_ADDR_ROW: addr_acc <= CW'(CW'(y_r) * CW'(EDGE)) + CW'(z_r);
      ST_ADDR_COL: addr_acc <= CW'(addr_acc * CW'(EDGE)) + CW'(x_r);
      ST_REDUCE:   if (addr_big) addr_acc <= addr_acc - CW'(CELLS);
      ST_DISPATCH: begin
        result_val  <= (op_r == OP_READ && mode != MODE_MIXED) ? implied : 8'd0;
        cnt         <= '0;
        all_zero    <= 1'b1;
        cells_match <= 1'b1;
        first_seen  <= 1'b0;
        rd_pend     <= 1'b0;
      end
      ST_READ: result_val <= rd_data;
      ST_FILL: cnt <= cnt + 1'b1;
      ST_SCAN: begin
        if (scan_issue) cnt <= cnt + 1'b1;
        rd_pend <= scan_issue;
        // read data is registered behind its address; cell zero arrives first
        if (rd_pend) begin
          if (!first_seen) begin
            first      <= rd_data;
            first_seen <= 1'b1;
          end else if (rd_data != first) begin
            cells_match <= 1'b0;
          end
          if (rd_data != 8'd0) all_zero <= 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data.read_value   <= result_val;
          out_data.storage_mode <= mode;
        end
      end
      default: rd_pend <= 1'b0;
    endcase
  end

endmodule

[src/vsms_checker.sv]
// Port-level checks for the voxel section mode store, bound to the top level.
module vsms_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input vsms_pkg::vsms_out_t out_data
);
  import vsms_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an accepted item keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second item at once");

  // empty mode never yields a nonzero cell value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_value != 8'd0 |-> out_data.storage_mode != MODE_EMPTY)
    else $error("nonzero read value in empty mode");

  // reset leaves no result pending and the block ready
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake not cleared by reset");

endmodule

bind voxel_section_mode_store vsms_checker u_vsms_checker (.*);
